### sv/imtmf_pkg.sv
// Shared types, constants and helpers of the impulse-noise trimmed median filter.
package imtmf_pkg;

    localparam int PIX_W       = 16;
    localparam int COL_W       = 12;
    localparam int ROW_W       = 16;
    localparam int MAX_WIDTH   = 2048;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int SIDE        = 3;
    localparam int AREA        = SIDE * SIDE;
    localparam int CENTER      = AREA / 2;
    localparam int NUM_BANKS   = SIDE + 1;
    localparam int BANK_W      = $clog2(NUM_BANKS);
    localparam int RSUM_W      = PIX_W + 2;
    localparam int SUM_W       = PIX_W + 4;
    localparam int CNT_W       = $clog2(AREA + 1);
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 23;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_NINE   = 20'd932068;
    localparam logic [PIX_W-1:0]   PIX_MAX      = 16'hFFFF;
    localparam logic [COL_W-1:0]   WIDTH_RESET  = 12'd640;
    localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd480;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [SIDE-1:0][BANK_W-1:0] row_sel;
        logic [ADDR_W-1:0]           col_a;
        logic [ADDR_W-1:0]           col_b;
        logic                        first;
        logic                        eol;
        logic                        eof;
    } t_rd_req;

    typedef struct packed {
        t_pix [AREA-1:0]              pix;
        logic [SIDE-1:0][RSUM_W-1:0]  row_sum;
        logic                         eol;
        logic                         eof;
    } t_win;

    function automatic logic is_mid(input t_pix v);
        return (v != '0) && (v != PIX_MAX);
    endfunction

endpackage

### sv/imtmf_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
module imtmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr_a,
    input  logic [AW-1:0]    i_rd_addr_b,
    output logic [WIDTH-1:0] o_rd_data_a,
    output logic [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

### sv/imtmf_ctrl.sv
// Position counters, line store write control and output scheduling.
module imtmf_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_accept,
    input  imtmf_pkg::t_pix               i_pixel,
    input  logic                          i_drain,
    input  logic [imtmf_pkg::COL_W-1:0]   i_width,
    input  logic [imtmf_pkg::ROW_W-1:0]   i_height,
    input  logic                          i_cfg_wr,
    output logic                          o_wr_en,
    output logic [imtmf_pkg::BANK_W-1:0]  o_wr_bank,
    output logic [imtmf_pkg::ADDR_W-1:0]  o_wr_col,
    output imtmf_pkg::t_pix               o_wr_data,
    output logic                          o_valid,
    output imtmf_pkg::t_rd_req            o_req
);
    import imtmf_pkg::*;

    logic [COL_W-1:0] r_in_col, r_out_col;
    logic [ROW_W-1:0] r_in_row, r_out_row;
    logic             r_valid;
    t_rd_req          r_req;

    logic [COL_W-1:0] n_in_col, n_out_col;
    logic [ROW_W-1:0] n_in_row, n_out_row;
    logic             wr, wrap, fire, eol, eof, can_out;
    logic [COL_W-1:0] in_col_inc, out_col_inc, ic1, nc;
    logic [ROW_W-1:0] ir1, nr, row_up;
    logic [ROW_W:0]   out_row_inc, h_ext;
    t_rd_req          n_req;

    always_comb begin
        wr          = i_accept && !i_drain && (r_in_row < i_height);
        in_col_inc  = r_in_col + COL_W'(1);
        wrap        = in_col_inc >= i_width;
        ic1         = wr ? (wrap ? '0 : in_col_inc) : r_in_col;
        ir1         = (wr && wrap) ? r_in_row + ROW_W'(1) : r_in_row;
        out_row_inc = {1'b0, r_out_row} + (ROW_W + 1)'(1);
        h_ext       = {1'b0, i_height};
        out_col_inc = r_out_col + COL_W'(1);
        nr          = (out_row_inc >= h_ext) ? i_height - ROW_W'(1) : out_row_inc[ROW_W-1:0];
        nc          = (out_col_inc >= i_width) ? i_width - COL_W'(1) : out_col_inc;
        can_out     = (ir1 >= i_height) || (nr < ir1) || ((nr == ir1) && (nc < ic1));
        fire        = i_accept && (r_out_row < i_height) && can_out;
        eol         = out_col_inc >= i_width;
        eof         = eol && (out_row_inc >= h_ext);
        row_up      = (r_out_row == '0) ? '0 : r_out_row - ROW_W'(1);

        n_req.row_sel[0] = row_up[BANK_W-1:0];
        n_req.row_sel[1] = r_out_row[BANK_W-1:0];
        n_req.row_sel[2] = nr[BANK_W-1:0];
        n_req.col_a      = r_out_col[ADDR_W-1:0];
        n_req.col_b      = nc[ADDR_W-1:0];
        n_req.first      = r_out_col == '0;
        n_req.eol        = eol;
        n_req.eof        = eof;

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_cfg_wr) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (i_accept) begin
            n_in_col = ic1;
            n_in_row = ir1;
            if (fire) begin
                if (eof) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (eol) begin
                    n_out_col = '0;
                    n_out_row = out_row_inc[ROW_W-1:0];
                end else begin
                    n_out_col = out_col_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            if (i_en) begin
                r_valid <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && fire) begin
            r_req <= n_req;
        end
    end

    assign o_wr_en   = wr;
    assign o_wr_bank = r_in_row[BANK_W-1:0];
    assign o_wr_col  = r_in_col[ADDR_W-1:0];
    assign o_wr_data = i_pixel;
    assign o_valid   = r_valid;
    assign o_req     = r_req;

endmodule

### sv/imtmf_window.sv
// Line store banks and 3x3 window assembly with row partial sums.
module imtmf_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_wr_en,
    input  logic [imtmf_pkg::BANK_W-1:0]  i_wr_bank,
    input  logic [imtmf_pkg::ADDR_W-1:0]  i_wr_col,
    input  imtmf_pkg::t_pix               i_wr_data,
    input  logic                          i_valid,
    input  imtmf_pkg::t_rd_req            i_req,
    output logic                          o_valid,
    output imtmf_pkg::t_win               o_win
);
    import imtmf_pkg::*;

    t_pix q_a [NUM_BANKS];
    t_pix q_b [NUM_BANKS];

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        imtmf_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .i_clk       (i_clk),
            .i_wr_en     (i_wr_en && (i_wr_bank == BANK_W'(b))),
            .i_wr_addr   (i_wr_col),
            .i_wr_data   (i_wr_data),
            .i_rd_en     (i_en),
            .i_rd_addr_a (i_req.col_a),
            .i_rd_addr_b (i_req.col_b),
            .o_rd_data_a (q_a[b]),
            .o_rd_data_b (q_b[b])
        );
    end

    logic             r2_valid;
    t_rd_req          r2_req;
    logic             r3_valid;
    t_win             r3_win;
    t_pix [SIDE-1:0]  r_prev;

    t_pix [SIDE-1:0]  cen, lft, rgt;
    t_win             n_win;

    always_comb begin
        for (int r = 0; r < SIDE; r++) begin
            cen[r] = q_a[r2_req.row_sel[r]];
            rgt[r] = q_b[r2_req.row_sel[r]];
            lft[r] = r2_req.first ? cen[r] : r_prev[r];
            n_win.pix[r*SIDE]     = lft[r];
            n_win.pix[r*SIDE + 1] = cen[r];
            n_win.pix[r*SIDE + 2] = rgt[r];
            n_win.row_sum[r] = RSUM_W'(lft[r]) + RSUM_W'(cen[r]) + RSUM_W'(rgt[r]);
        end
        n_win.eol = r2_req.eol;
        n_win.eof = r2_req.eof;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= i_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_req <= i_req;
            if (r2_valid) begin
                r3_win <= n_win;
                r_prev <= cen;
            end
        end
    end

    assign o_valid = r3_valid;
    assign o_win   = r3_win;

endmodule

### sv/imtmf_select.sv
// Mean by reciprocal multiply, rank-based trimmed median and output register.
module imtmf_select (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  imtmf_pkg::t_win   i_win,
    output logic              o_valid,
    output imtmf_pkg::t_pix   o_filtered,
    output logic              o_eol,
    output logic              o_eof
);
    import imtmf_pkg::*;

    // stage 4
    logic                       r4_valid, r4_eol, r4_eof;
    t_pix [AREA-1:0]            r4_pix;
    logic [AREA-1:0]            r4_mid;
    logic [AREA-1:0][AREA-1:0]  r4_prec;
    logic [SUM_W-1:0]           r4_sum;
    // stage 5
    logic                       r5_valid, r5_eol, r5_eof, r5_use_mean;
    logic [PROD_W-1:0]          r5_prod;
    t_pix                       r5_med;
    // output
    logic                       r6_valid, r6_eol, r6_eof;
    t_pix                       r6_filtered;

    logic [AREA-1:0]            mid;
    logic [AREA-1:0][PIX_W:0]   key;
    logic [AREA-1:0][AREA-1:0]  prec;
    logic [SUM_W-1:0]           sum;
    logic [CNT_W-1:0]           nk, kidx;
    logic [AREA-1:0][CNT_W-1:0] rank;
    t_pix                       med;

    always_comb begin
        sum = '0;
        for (int r = 0; r < SIDE; r++) begin
            sum = sum + SUM_W'(i_win.row_sum[r]);
        end
        for (int i = 0; i < AREA; i++) begin
            mid[i] = is_mid(i_win.pix[i]);
            key[i] = {!mid[i], i_win.pix[i]};
        end
        for (int i = 0; i < AREA; i++) begin
            for (int j = 0; j < AREA; j++) begin
                prec[i][j] = (key[j] < key[i]) || ((key[j] == key[i]) && (j < i));
            end
        end
    end

    always_comb begin
        nk   = CNT_W'($countones(r4_mid));
        kidx = nk >> 1;
        med  = '0;
        for (int i = 0; i < AREA; i++) begin
            rank[i] = CNT_W'($countones(r4_prec[i]));
            if (r4_mid[i] && (rank[i] == kidx)) begin
                med = med | r4_pix[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= i_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_pix  <= i_win.pix;
            r4_mid  <= mid;
            r4_prec <= prec;
            r4_sum  <= sum;
            r4_eol  <= i_win.eol;
            r4_eof  <= i_win.eof;

            r5_prod     <= PROD_W'(r4_sum) * PROD_W'(RECIP_NINE);
            r5_med      <= med;
            r5_use_mean <= r4_mid[CENTER] || (nk == '0);
            r5_eol      <= r4_eol;
            r5_eof      <= r4_eof;

            r6_filtered <= r5_use_mean ? r5_prod[RECIP_SHIFT +: PIX_W] : r5_med;
            r6_eol      <= r5_eol;
            r6_eof      <= r5_eof;
        end
    end

    assign o_valid    = r6_valid;
    assign o_filtered = r6_filtered;
    assign o_eol      = r6_eol;
    assign o_eof      = r6_eof;

endmodule

### sv/impulse_noise_trimmed_median_filter_core.sv
// Impulse-noise trimmed median filter, top level with stream and register ports.
//
// Pixels enter in raster order, one request per clock while s_axis_tready is
// high; each accepted request yields at most one filtered pixel. A result is
// scheduled as soon as every pixel of its 3x3 neighbourhood (edges replicated)
// has arrived, so results trail the input by about one row plus one pixel;
// drain requests (tuser = 1) push out the last rows after a frame. The
// datapath is a six stage pipeline ending in the output register. The whole
// pipeline stalls together only while a result waits in the output register
// and m_axis_tready is low. The line store is four bank RAMs of 2048 pixels,
// one row per bank; no clearing pass is needed. Registers: image_width at
// 0x0, image_height at 0x4; a write restarts the frame.
module impulse_noise_trimmed_median_filter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] pixel
    input  logic [0:0]  i_s_axis_tuser,   // [0] drain
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] filtered
    output logic        o_m_axis_tlast,
    output logic [0:0]  o_m_axis_tuser,   // [0] end_of_frame
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import imtmf_pkg::*;

    logic [COL_W-1:0]  r_width;
    logic [ROW_W-1:0]  r_height;
    logic [COL_W-1:0]  eff_width;
    logic [ROW_W-1:0]  eff_height;
    logic              cfg_wr, en, accept;
    logic              wr_en, c_valid, w_valid;
    logic [BANK_W-1:0] wr_bank;
    logic [ADDR_W-1:0] wr_col;
    t_pix              wr_data;
    t_rd_req           req;
    t_win              win;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[COL_W-1:0];
                REG_HEIGHT: r_height <= pwdata[ROW_W-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = {{(32-COL_W){1'b0}}, r_width};
            REG_HEIGHT: prdata = {{(32-ROW_W){1'b0}}, r_height};
            default:    prdata = '0;
        endcase
    end

    assign eff_width  = (r_width == '0) ? COL_W'(1) :
                        (r_width > COL_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH) : r_width;
    assign eff_height = (r_height == '0) ? ROW_W'(1) : r_height;

    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign accept          = i_s_axis_tvalid && en;

    imtmf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_accept  (accept),
        .i_pixel   (i_s_axis_tdata),
        .i_drain   (i_s_axis_tuser[0]),
        .i_width   (eff_width),
        .i_height  (eff_height),
        .i_cfg_wr  (cfg_wr),
        .o_wr_en   (wr_en),
        .o_wr_bank (wr_bank),
        .o_wr_col  (wr_col),
        .o_wr_data (wr_data),
        .o_valid   (c_valid),
        .o_req     (req)
    );

    imtmf_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_wr_en   (wr_en),
        .i_wr_bank (wr_bank),
        .i_wr_col  (wr_col),
        .i_wr_data (wr_data),
        .i_valid   (c_valid),
        .i_req     (req),
        .o_valid   (w_valid),
        .o_win     (win)
    );

    imtmf_select u_select (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (w_valid),
        .i_win      (win),
        .o_valid    (o_m_axis_tvalid),
        .o_filtered (o_m_axis_tdata),
        .o_eol      (o_m_axis_tlast),
        .o_eof      (o_m_axis_tuser[0])
    );

endmodule

### sv/imtmf_checker.sv
// Port-level checks of the filter core, bound to the top level.
module imtmf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] i_m_tdata,
    input logic        i_m_tlast,
    input logic        i_m_tuser,
    input logic        i_pready
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) &&
            $stable(i_m_tlast) && $stable(i_m_tuser))
        else $error("stalled result changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_tvalid |-> i_s_tready)
        else $error("input blocked with empty output");

    a_eof_is_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser |-> i_m_tlast)
        else $error("frame end without line end");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

endmodule

bind impulse_noise_trimmed_median_filter_core imtmf_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast),
    .i_m_tuser  (o_m_axis_tuser[0]),
    .i_pready   (pready)
);

### bench/tb_top.sv
// Self-checking bench for the impulse-noise trimmed median filter core.
module tb_top;
    import imtmf_pkg::*;

    typedef enum logic [1:0] {OP_PIX, OP_DRAIN, OP_SET_W, OP_SET_H} t_op;

    typedef struct {
        t_op         op;
        logic [31:0] val;
        logic        chk;
        t_pix        filt;
        logic        eol;
        logic        eof;
    } t_row;

    typedef struct {
        t_pix filt;
        logic eol;
        logic eof;
    } t_outpix;

    localparam logic [2:0] ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;
    localparam int LATENCY = 12;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [15:0] s_data = '0;
    logic [0:0]  s_user = '0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_data;
    logic        m_last;
    logic [0:0]  m_user;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    impulse_noise_trimmed_median_filter_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tlast(m_last), .o_m_axis_tuser(m_user),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // filter model state
    t_pix        rows_mem [NUM_BANKS][MAX_WIDTH];
    logic [11:0] width_reg = 12'd640;
    logic [15:0] height_reg = 16'd480;
    int unsigned in_col, in_row, out_col, out_row;
    bit          frame_done;
    t_outpix     pending_pix [$];

    int  errors = 0;
    int  cycles = 0;
    bit  idle_en = 1'b1;
    int  sent = 0;

    function automatic t_pix filter_pixel(int unsigned r0, int unsigned c0,
                                          int unsigned w, int unsigned h);
        t_pix        win [AREA];
        t_pix        keep [AREA];
        t_pix        v;
        int unsigned sum, nk, k, j, r, c;
        int          di, dj;
        sum = 0; nk = 0; k = 0;
        for (di = -1; di <= 1; di++) begin
            r = (int'(r0) + di < 0) ? 0 : (r0 + di > h - 1) ? h - 1 : r0 + di;
            for (dj = -1; dj <= 1; dj++) begin
                c = (int'(c0) + dj < 0) ? 0 : (c0 + dj > w - 1) ? w - 1 : c0 + dj;
                win[k] = rows_mem[r % NUM_BANKS][c % MAX_WIDTH];
                sum += win[k];
                k++;
            end
        end
        if (win[CENTER] != 0 && win[CENTER] != 16'hFFFF) return t_pix'(sum / AREA);
        for (k = 0; k < AREA; k++) begin
            v = win[k];
            if (v != 0 && v != 16'hFFFF) begin
                j = nk;
                while (j > 0 && keep[j-1] > v) begin
                    keep[j] = keep[j-1];
                    j--;
                end
                keep[j] = v;
                nk++;
            end
        end
        if (nk == 0) return t_pix'(sum / AREA);
        return keep[nk / 2];
    endfunction

    // advance the model by one accepted request; returns 1 with a result
    function automatic bit filter_step(bit drain, t_pix pix, output t_outpix res);
        int unsigned w, h, nr, nc;
        longint unsigned need, got;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg == 0) ? 1 : height_reg;
        if (!drain && in_row < h) begin
            rows_mem[in_row % NUM_BANKS][in_col % MAX_WIDTH] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        if (out_row >= h) return 1'b0;
        nr = (out_row + 1 > h - 1) ? h - 1 : out_row + 1;
        nc = (out_col + 1 > w - 1) ? w - 1 : out_col + 1;
        need = longint'(nr) * w + nc;
        got  = longint'(in_row) * w + in_col;
        if (in_row < h && need >= got) return 1'b0;
        res.filt = filter_pixel(out_row, out_col, w, h);
        res.eol  = (out_col + 1 >= w);
        res.eof  = res.eol && (out_row + 1 >= h);
        if (res.eof) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            frame_done = 1'b1;
        end else if (res.eol) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
        return 1'b1;
    endfunction

    task automatic report(string what, int unsigned exp_v, int unsigned got_v);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_pix.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        logic [31:0] rd;
        wait_idle();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (addr == ADDR_WIDTH) width_reg = data[11:0];
        else height_reg = data[15:0];
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        pwrite <= 1'b0; penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
        if (addr == ADDR_WIDTH && rd[11:0] != width_reg) report("width reg", width_reg, rd);
        if (addr == ADDR_HEIGHT && rd[15:0] != height_reg) report("height reg", height_reg, rd);
    endtask

    // drive one request; called at a falling edge, returns at a falling edge
    task automatic send_req(bit drain, t_pix pix, bit chk = 0, t_outpix typed = '{0, 0, 0});
        t_outpix res;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= pix;
        s_user  <= drain;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        if (filter_step(drain, pix, res)) begin
            if (chk) res = typed;
            pending_pix = {pending_pix, res};
        end
        sent++;
        @(negedge i_clk);
    endtask

    function automatic t_pix rand_pix();
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'h0000;
            3, 4, 5: return 16'hFFFF;
            default: return t_pix'($urandom);
        endcase
    endfunction

    task automatic flush_frame();
        while (!frame_done) send_req($urandom_range(0, 3) != 0, t_pix'($urandom));
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_outpix e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL impulse_noise_trimmed_median_filter_core");
            $finish;
        end
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_pix.size() == 0) begin
                report("unexpected result", 0, m_data);
            end else begin
                e = pending_pix.pop_front();
                if (m_data != e.filt) report("filtered", e.filt, m_data);
                if (m_last != e.eol) report("end_of_line", e.eol, m_last);
                if (m_user[0] != e.eof) report("end_of_frame", e.eof, m_user[0]);
            end
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_en && i_rst_n && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            m_ready <= 1'b1;
        end
    end

    t_row dir_tab [] = '{
        '{OP_SET_W, 32'd1,     0, 0,     0, 0},
        '{OP_SET_H, 32'd1,     0, 0,     0, 0},
        '{OP_PIX,   32'd0,     1, 0,     1, 1},
        '{OP_PIX,   32'd65535, 1, 65535, 1, 1},
        '{OP_PIX,   32'd1234,  1, 1234,  1, 1},
        '{OP_DRAIN, 32'd0,     0, 0,     0, 0},
        '{OP_SET_W, 32'd3,     0, 0,     0, 0},
        '{OP_SET_H, 32'd2,     0, 0,     0, 0},
        '{OP_PIX,   32'd0,     0, 0,     0, 0},
        '{OP_PIX,   32'd65535, 0, 0,     0, 0},
        '{OP_DRAIN, 32'd0,     0, 0,     0, 0},
        '{OP_PIX,   32'd100,   0, 0,     0, 0},
        '{OP_PIX,   32'd65535, 0, 0,     0, 0},
        '{OP_PIX,   32'd0,     0, 0,     0, 0},
        '{OP_PIX,   32'd200,   0, 0,     0, 0},
        '{OP_DRAIN, 32'd0,     0, 0,     0, 0},
        '{OP_DRAIN, 32'd0,     0, 0,     0, 0},
        '{OP_PIX,   32'd5,     0, 0,     0, 0},
        '{OP_DRAIN, 32'd0,     0, 0,     0, 0},
        '{OP_SET_W, 32'h1000,  0, 0,     0, 0},
        '{OP_SET_H, 32'hF0000, 0, 0,     0, 0},
        '{OP_PIX,   32'd7,     1, 7,     1, 1}
    };

    initial begin
        int w, h, n, cut;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[i]) begin
            case (dir_tab[i].op)
                OP_SET_W: reg_write(ADDR_WIDTH, dir_tab[i].val);
                OP_SET_H: reg_write(ADDR_HEIGHT, dir_tab[i].val);
                OP_PIX:   send_req(1'b0, dir_tab[i].val[15:0], dir_tab[i].chk,
                                   '{dir_tab[i].filt, dir_tab[i].eol, dir_tab[i].eof});
                default:  send_req(1'b1, t_pix'($urandom));
            endcase
        end

        // clamped width and tallest frame, both abandoned early
        reg_write(ADDR_WIDTH, 32'd4095);
        reg_write(ADDR_HEIGHT, 32'd1);
        frame_done = 0;
        for (int i = 0; i < 40; i++) send_req(1'b0, rand_pix());
        reg_write(ADDR_WIDTH, 32'd1);
        reg_write(ADDR_HEIGHT, 32'd65535);
        for (int i = 0; i < 8; i++) send_req(1'b0, rand_pix());

        while (sent < 500) begin
            if (sent > 420) idle_en = 1'b0;
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 6);
            reg_write(ADDR_WIDTH, w | ($urandom_range(0, 3) == 0 ? 32'hA000 : 0));
            reg_write(ADDR_HEIGHT, h);
            frame_done = 0;
            n = w * h;
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
            for (int i = 0; i < cut; i++) begin
                if ($urandom_range(0, 11) == 0) send_req(1'b1, t_pix'($urandom));
                send_req(1'b0, rand_pix());
            end
            if (cut == n) flush_frame();
        end

        wait_idle();
        if (errors == 0)
            $display("PASS impulse_noise_trimmed_median_filter_core");
        else
            $display("FAIL impulse_noise_trimmed_median_filter_core");
        $finish;
    end
endmodule
